@@ rtl/core/sce_pkg.sv @@
// Types, row codes and arithmetic helpers shared by the chordal error core.
package sce_pkg;

    localparam int FRONT_STAGES = 3;
    localparam int INFLIGHT_W   = 2;

    localparam logic [2:0] ROW_R00 = 3'd0;
    localparam logic [2:0] ROW_R10 = 3'd1;
    localparam logic [2:0] ROW_R01 = 3'd2;
    localparam logic [2:0] ROW_R11 = 3'd3;
    localparam logic [2:0] ROW_TX  = 3'd4;
    localparam logic [2:0] ROW_TY  = 3'd5;

    localparam logic signed [33:0] ROUND_ROT = 34'sd2048;
    localparam logic signed [50:0] ROUND_TRN = 51'sd8192;
    localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
    localparam logic signed [31:0] NEG_ONE   = -32'sd65536;

    typedef struct packed {
        logic signed [15:0] from_cos;
        logic signed [15:0] from_sin;
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [15:0] to_cos;
        logic signed [15:0] to_sin;
        logic signed [31:0] to_x;
        logic signed [31:0] to_y;
        logic signed [15:0] meas_cos;
        logic signed [15:0] meas_sin;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
    } t_item;

    typedef struct packed {
        logic        [2:0]  row_index;
        logic signed [31:0] error_value;
        logic signed [31:0] jac_from_dx;
        logic signed [31:0] jac_from_dy;
        logic signed [31:0] jac_from_dtheta;
        logic signed [31:0] jac_to_dx;
        logic signed [31:0] jac_to_dy;
        logic signed [31:0] jac_to_dtheta;
        logic               last_row;
    } t_result;

    typedef struct packed {
        logic signed [21:0] c;
        logic signed [21:0] s;
        logic signed [36:0] px;
        logic signed [36:0] py;
        logic signed [15:0] meas_cos;
        logic signed [15:0] meas_sin;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
    } t_entry;

    typedef struct packed {
        logic                  push;
        logic [INFLIGHT_W-1:0] inflight;
    } t_front_stat;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [31:0] r;
        if (x > 38'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/sce_front.sv @@
// Front pipeline: accept a factor and form the rounded relative prediction.
module sce_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  sce_pkg::t_item       i_item,
    output sce_pkg::t_front_stat o_stat,
    output sce_pkg::t_entry      o_entry
);

    logic [sce_pkg::FRONT_STAGES-1:0] r_vld;

    logic signed [15:0] r_fc, r_fs, r_tc, r_ts, r_mc1, r_ms1;
    logic signed [32:0] r_dx, r_dy;
    logic signed [31:0] r_mx1, r_my1;

    logic signed [31:0] r_cc, r_ss, r_cs, r_sc;
    logic signed [48:0] r_xa, r_xb, r_ya, r_yb;
    logic signed [15:0] r_mc2, r_ms2;
    logic signed [31:0] r_mx2, r_my2;

    logic signed [33:0] n_sum_c, n_sum_s;
    logic signed [50:0] n_sum_x, n_sum_y;

    sce_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[sce_pkg::FRONT_STAGES-2:0], i_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_fc  <= i_item.from_cos;
        r_fs  <= i_item.from_sin;
        r_tc  <= i_item.to_cos;
        r_ts  <= i_item.to_sin;
        r_dx  <= 33'(i_item.to_x) - 33'(i_item.from_x);
        r_dy  <= 33'(i_item.to_y) - 33'(i_item.from_y);
        r_mc1 <= i_item.meas_cos;
        r_ms1 <= i_item.meas_sin;
        r_mx1 <= i_item.meas_x;
        r_my1 <= i_item.meas_y;

        r_cc  <= r_fc * r_tc;
        r_ss  <= r_fs * r_ts;
        r_cs  <= r_fc * r_ts;
        r_sc  <= r_fs * r_tc;
        r_xa  <= 49'(r_fc) * 49'(r_dx);
        r_xb  <= 49'(r_fs) * 49'(r_dy);
        r_ya  <= 49'(r_fc) * 49'(r_dy);
        r_yb  <= 49'(r_fs) * 49'(r_dx);
        r_mc2 <= r_mc1;
        r_ms2 <= r_ms1;
        r_mx2 <= r_mx1;
        r_my2 <= r_my1;
    end

    always_comb begin
        n_sum_c = 34'(r_cc) + 34'(r_ss) + sce_pkg::ROUND_ROT;
        n_sum_s = 34'(r_cs) - 34'(r_sc) + sce_pkg::ROUND_ROT;
        n_sum_x = 51'(r_xa) + 51'(r_xb) + sce_pkg::ROUND_TRN;
        n_sum_y = 51'(r_ya) - 51'(r_yb) + sce_pkg::ROUND_TRN;
    end

    always_ff @(posedge i_clk) begin
        r_entry.c        <= n_sum_c[33:12];
        r_entry.s        <= n_sum_s[33:12];
        r_entry.px       <= n_sum_x[50:14];
        r_entry.py       <= n_sum_y[50:14];
        r_entry.meas_cos <= r_mc2;
        r_entry.meas_sin <= r_ms2;
        r_entry.meas_x   <= r_mx2;
        r_entry.meas_y   <= r_my2;
    end

    assign o_entry         = r_entry;
    assign o_stat.push     = r_vld[sce_pkg::FRONT_STAGES-1];
    assign o_stat.inflight = sce_pkg::INFLIGHT_W'(r_vld[0])
                           + sce_pkg::INFLIGHT_W'(r_vld[1])
                           + sce_pkg::INFLIGHT_W'(r_vld[2]);

endmodule

@@ rtl/core/sce_queue.sv @@
// Queue of predictions between the front pipeline and the row sequencer.
module sce_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sce_pkg::t_front_stat i_stat,
    input  sce_pkg::t_entry      i_entry,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output sce_pkg::t_entry      o_head
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = $clog2(DEPTH + sce_pkg::FRONT_STAGES + 1);

    sce_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   n_fill;

    always_ff @(posedge i_clk) begin
        if (i_stat.push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_stat.push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_stat.push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_stat.push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign n_fill  = SW'(r_count) + SW'(i_stat.inflight);
    assign o_full  = n_fill >= SW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.push && !i_pop |-> r_count < CW'(DEPTH))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_fill <= SW'(DEPTH + sce_pkg::FRONT_STAGES))
        else $error("items in flight exceed queue room");
`endif

endmodule

@@ rtl/core/sce_back.sv @@
// Row sequencer: emit six error and Jacobian rows per prediction.
module sce_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_err_only,
    input  logic             i_q_empty,
    input  sce_pkg::t_entry  i_head,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output sce_pkg::t_result o_result
);

    logic [2:0]       r_row;
    logic             r_out_vld;
    sce_pkg::t_result r_out;
    sce_pkg::t_result n_res;
    logic             n_load;

    logic signed [31:0] n_c, n_s, n_mc, n_ms, n_err_c, n_err_s;
    logic signed [31:0] n_err_x, n_err_y, n_pxs, n_pys, n_npxs;

    always_comb begin
        n_c     = 32'(i_head.c);
        n_s     = 32'(i_head.s);
        n_mc    = {{14{i_head.meas_cos[15]}}, i_head.meas_cos, 2'b00};
        n_ms    = {{14{i_head.meas_sin[15]}}, i_head.meas_sin, 2'b00};
        n_err_c = n_c - n_mc;
        n_err_s = n_s - n_ms;
        n_err_x = sce_pkg::sat32(38'(i_head.px) - 38'(i_head.meas_x));
        n_err_y = sce_pkg::sat32(38'(i_head.py) - 38'(i_head.meas_y));
        n_pxs   = sce_pkg::sat32(38'(i_head.px));
        n_pys   = sce_pkg::sat32(38'(i_head.py));
        n_npxs  = sce_pkg::sat32(-38'(n_pxs));

        n_res                 = '0;
        n_res.row_index       = r_row;
        n_res.last_row        = r_row == sce_pkg::ROW_TY;
        case (r_row)
            sce_pkg::ROW_R00, sce_pkg::ROW_R11: begin
                n_res.error_value     = n_err_c;
                n_res.jac_from_dtheta = n_s;
                n_res.jac_to_dtheta   = -n_s;
            end
            sce_pkg::ROW_R10: begin
                n_res.error_value     = n_err_s;
                n_res.jac_from_dtheta = -n_c;
                n_res.jac_to_dtheta   = n_c;
            end
            sce_pkg::ROW_R01: begin
                n_res.error_value     = -n_err_s;
                n_res.jac_from_dtheta = n_c;
                n_res.jac_to_dtheta   = -n_c;
            end
            sce_pkg::ROW_TX: begin
                n_res.error_value     = n_err_x;
                n_res.jac_from_dx     = sce_pkg::NEG_ONE;
                n_res.jac_from_dtheta = n_pys;
                n_res.jac_to_dx       = n_c;
                n_res.jac_to_dy       = -n_s;
            end
            sce_pkg::ROW_TY: begin
                n_res.error_value     = n_err_y;
                n_res.jac_from_dy     = sce_pkg::NEG_ONE;
                n_res.jac_from_dtheta = n_npxs;
                n_res.jac_to_dx       = n_s;
                n_res.jac_to_dy       = n_c;
            end
            default: begin
                n_res.error_value = '0;
            end
        endcase
        if (i_err_only) begin
            n_res.jac_from_dx     = '0;
            n_res.jac_from_dy     = '0;
            n_res.jac_from_dtheta = '0;
            n_res.jac_to_dx       = '0;
            n_res.jac_to_dy       = '0;
            n_res.jac_to_dtheta   = '0;
        end
    end

    assign n_load  = !i_q_empty && (!r_out_vld || i_pop);
    assign o_q_pop = n_load && (r_row == sce_pkg::ROW_TY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= sce_pkg::ROW_R00;
            r_out_vld <= 1'b0;
        end else begin
            if (n_load) begin
                r_row     <= (r_row == sce_pkg::ROW_TY) ? sce_pkg::ROW_R00 : r_row + 1'b1;
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= n_res;
        end
    end

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= sce_pkg::ROW_TY)
        else $error("row counter out of range");
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_out_vld && r_out.last_row && r_row == sce_pkg::ROW_R00)
        else $error("prediction released before its last row");
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load && r_out_vld && r_out.row_index != sce_pkg::ROW_TY
        |-> r_row == r_out.row_index + 3'd1)
        else $error("rows out of order");
`endif

endmodule

@@ rtl/core/se2_chordal_error_jacobian_core.sv @@
// Top level of the planar pose-pose chordal error and Jacobian core.
// Each accepted factor yields six result rows, one per cycle from the row sequencer
// while the output register is empty or popped. The first row of a factor, if the
// output is drained, passes three front pipeline stages (difference, multiply, round),
// the first taken at the edge that accepts it, then a queue write and the output
// register. Up to QUEUE_DEPTH factors, counting those still in the front pipeline,
// can be held ahead of the row sequencer; full rises when that room is taken.
// The error_only_mode register is written through the configuration channel,
// which is always ready, and zeroes every Jacobian field of later rows.
module se2_chordal_error_jacobian_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  sce_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output sce_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);

    logic                 r_err_only;
    logic                 q_full, q_empty, q_pop, back_empty;
    sce_pkg::t_front_stat front_stat;
    sce_pkg::t_entry      front_entry, q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_only <= 1'b0;
        end else if (i_cfg_valid) begin
            r_err_only <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign empty       = back_empty;

    sce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (push && !q_full),
        .i_item   (i_item),
        .o_stat   (front_stat),
        .o_entry  (front_entry)
    );

    sce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (front_stat),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    sce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_err_only (r_err_only),
        .i_q_empty  (q_empty),
        .i_head     (q_head),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (back_empty),
        .o_result   (o_result)
    );

endmodule

@@ tb/sv/se2_chordal_row_checker.sv @@
`timescale 1ns / 1ps
// Row checker: predicts the six error and Jacobian rows of each factor and compares them.
module se2_chordal_row_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  sce_pkg::t_item   i_item,
    input  logic             i_empty,
    input  logic             i_pop,
    input  sce_pkg::t_result i_result,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic             i_cfg_data,
    output int               o_mismatches,
    output int               o_rows_waiting
);
    import sce_pkg::*;

    t_result expected_rows[$];
    logic    jac_muted = 1'b0;

    function automatic logic signed [31:0] clip32(input longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_result make_row(input logic [2:0] code, input longint err,
                                         input longint fdx, input longint fdy,
                                         input longint fdt, input longint tdx,
                                         input longint tdy, input longint tdt,
                                         input logic muted);
        t_result r;
        r.row_index       = code;
        r.error_value     = clip32(err);
        r.jac_from_dx     = muted ? '0 : clip32(fdx);
        r.jac_from_dy     = muted ? '0 : clip32(fdy);
        r.jac_from_dtheta = muted ? '0 : clip32(fdt);
        r.jac_to_dx       = muted ? '0 : clip32(tdx);
        r.jac_to_dy       = muted ? '0 : clip32(tdy);
        r.jac_to_dtheta   = muted ? '0 : clip32(tdt);
        r.last_row        = (code == ROW_TY);
        return r;
    endfunction

    task automatic predict_factor_rows(input t_item f);
        longint fc, fs, tc, ts, mc, ms, mx, my, dx, dy;
        longint c, s, px, py, pxs, pys, one;
        fc  = f.from_cos;
        fs  = f.from_sin;
        tc  = f.to_cos;
        ts  = f.to_sin;
        mc  = longint'(f.meas_cos) * 4;
        ms  = longint'(f.meas_sin) * 4;
        mx  = f.meas_x;
        my  = f.meas_y;
        dx  = longint'(f.to_x) - longint'(f.from_x);
        dy  = longint'(f.to_y) - longint'(f.from_y);
        c   = (fc * tc + fs * ts + 2048) >>> 12;
        s   = (fc * ts - fs * tc + 2048) >>> 12;
        px  = (fc * dx + fs * dy + 8192) >>> 14;
        py  = (fc * dy - fs * dx + 8192) >>> 14;
        pxs = clip32(px);
        pys = clip32(py);
        one = ONE_Q16;
        expected_rows.push_back(make_row(ROW_R00, c - mc, 0, 0, s, 0, 0, -s, jac_muted));
        expected_rows.push_back(make_row(ROW_R10, s - ms, 0, 0, -c, 0, 0, c, jac_muted));
        expected_rows.push_back(make_row(ROW_R01, ms - s, 0, 0, c, 0, 0, -c, jac_muted));
        expected_rows.push_back(make_row(ROW_R11, c - mc, 0, 0, s, 0, 0, -s, jac_muted));
        expected_rows.push_back(make_row(ROW_TX, px - mx, -one, 0, pys, c, -s, 0, jac_muted));
        expected_rows.push_back(make_row(ROW_TY, py - my, 0, -one, -pxs, s, c, 0, jac_muted));
    endtask

    task automatic check_field(input string name, input logic [2:0] row,
                               input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("row %0d %s: expected %0d, got %0d", row, name, want_v, got_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            jac_muted = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                jac_muted = i_cfg_data;
            end
            if (i_pop && !i_empty) begin
                if (expected_rows.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("row %0d transferred with no factor outstanding",
                                 i_result.row_index);
                    end
                end else begin
                    want = expected_rows.pop_front();
                    check_field("row_index", want.row_index, want.row_index,
                                i_result.row_index);
                    check_field("error_value", want.row_index, want.error_value,
                                i_result.error_value);
                    check_field("jac_from_dx", want.row_index, want.jac_from_dx,
                                i_result.jac_from_dx);
                    check_field("jac_from_dy", want.row_index, want.jac_from_dy,
                                i_result.jac_from_dy);
                    check_field("jac_from_dtheta", want.row_index, want.jac_from_dtheta,
                                i_result.jac_from_dtheta);
                    check_field("jac_to_dx", want.row_index, want.jac_to_dx,
                                i_result.jac_to_dx);
                    check_field("jac_to_dy", want.row_index, want.jac_to_dy,
                                i_result.jac_to_dy);
                    check_field("jac_to_dtheta", want.row_index, want.jac_to_dtheta,
                                i_result.jac_to_dtheta);
                    check_field("last_row", want.row_index, want.last_row,
                                i_result.last_row);
                end
            end
            if (i_push && !i_full) begin
                predict_factor_rows(i_item);
            end
        end
        o_rows_waiting = expected_rows.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: drives factors and mode writes into the chordal error core and gives the verdict.
module tb;
    import sce_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_PER_PHASE = 42;

    localparam logic signed [15:0] UNIT    = 16'sd16384;
    localparam logic signed [15:0] H_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] H_MIN   = 16'sh8000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    push      = 1'b0;
    logic    full;
    t_item   item      = '0;
    logic    empty;
    logic    pop       = 1'b0;
    t_result result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_data  = 1'b0;

    int mismatches;
    int rows_waiting;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int idle_by_phase[4]   = '{0, 79, 0, 31};
    int stall_by_phase[4]  = '{0, 0, 79, 31};

    se2_chordal_error_jacobian_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_item     (item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (result),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    se2_chordal_row_checker u_row_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_item        (item),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result      (result),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_rows_waiting(rows_waiting)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        pop <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [15:0] random_heading();
        logic signed [15:0] h;
        case ($urandom_range(0, 9))
            0: h = 16'($urandom);
            1: h = ($urandom_range(0, 1) != 0) ? UNIT : -UNIT;
            default: h = 16'($urandom_range(0, 32768) - 16384);
        endcase
        return h;
    endfunction

    function automatic logic signed [31:0] random_position();
        logic signed [31:0] p;
        case ($urandom_range(0, 7))
            0, 1: p = $urandom;
            2: p = ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
            default: p = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
        endcase
        return p;
    endfunction

    function automatic t_item random_factor();
        t_item f;
        f.from_cos = random_heading();
        f.from_sin = random_heading();
        f.from_x   = random_position();
        f.from_y   = random_position();
        f.to_cos   = random_heading();
        f.to_sin   = random_heading();
        f.to_x     = random_position();
        f.to_y     = random_position();
        f.meas_cos = random_heading();
        f.meas_sin = random_heading();
        f.meas_x   = random_position();
        f.meas_y   = random_position();
        return f;
    endfunction

    task automatic send_factor(input t_item f);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= f;
        do @(posedge clk); while (full);
    endtask

    task automatic drain_rows();
        @(negedge clk);
        push <= 1'b0;
        while (rows_waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_corner_factors();
        send_factor(t_item'{16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0,
                            16'sd0, 16'sd0, 32'sd0, 32'sd0});
        send_factor(t_item'{UNIT, 16'sd0, 32'sd0, 32'sd0, UNIT, 16'sd0, 32'sd0, 32'sd0,
                            UNIT, 16'sd0, 32'sd0, 32'sd0});
        send_factor(t_item'{16'sd0, UNIT, 32'sh00010000, -32'sh00020000,
                            -UNIT, 16'sd0, 32'sh00030000, 32'sh00008000,
                            16'sd0, -UNIT, 32'sh00012345, -32'sh00004000});
        send_factor(t_item'{H_MAX, H_MAX, POS_MIN, POS_MIN, H_MAX, H_MAX, POS_MAX, POS_MAX,
                            H_MAX, H_MAX, POS_MIN, POS_MAX});
        send_factor(t_item'{H_MIN, H_MIN, POS_MAX, POS_MAX, H_MIN, H_MIN, POS_MIN, POS_MIN,
                            H_MIN, H_MIN, POS_MAX, POS_MIN});
        send_factor(t_item'{UNIT, 16'sd0, 32'sd0, 32'sd0, UNIT, 16'sd0, POS_MIN, POS_MAX,
                            -UNIT, UNIT, 32'sd0, 32'sd0});
        send_factor(t_item'{UNIT, 16'sd0, 32'sd0, 32'sd0, UNIT, 16'sd0, POS_MAX, POS_MIN,
                            UNIT, 16'sd0, POS_MIN, POS_MAX});
        send_factor(t_item'{UNIT, 16'sd0, 32'sd5, 32'sd5, UNIT, 16'sd0, 32'sd5, 32'sd5,
                            H_MAX, H_MIN, POS_MIN, POS_MAX});
        send_factor(t_item'{16'sd11585, 16'sd11585, 32'sd1, -32'sd1,
                            16'sd11585, -16'sd11585, -32'sd3, 32'sd7,
                            16'sd0, UNIT, -32'sd1, 32'sd1});
        send_factor(t_item'{-UNIT, 16'sd0, 32'sh12345678, -32'sh0ABCDEF0,
                            16'sd0, -UNIT, -32'sh01234567, 32'sh07654321,
                            UNIT, 16'sd0, 32'sd0, 32'sd0});
        send_factor(t_item'{16'sd1, 16'sd0, 32'sd0, 32'sd0, -16'sd2048, 16'sd2048,
                            -32'sd8192, 32'sd8192, 16'sd0, 16'sd0, 32'sd0, 32'sd0});
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);
        send_corner_factors();
        drain_rows();
        write_mode(1'b1);
        send_corner_factors();

        for (int phase = 0; phase < 4; phase++) begin
            drain_rows();
            write_mode(phase % 2 == 0);
            sender_idle_pct    = idle_by_phase[phase];
            receiver_stall_pct = stall_by_phase[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 3 && n == RANDOM_PER_PHASE / 2) begin
                    drain_rows();
                end
                send_factor(random_factor());
            end
        end
        drain_rows();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
